@@ src/upwind_gradient_magnitude_defines.svh @@
// Assertion macros for the upwind gradient magnitude checker.
// Depends on nothing; the using scope must provide clk and rst.
`ifndef UPWIND_GRADIENT_MAGNITUDE_DEFINES_SVH
`define UPWIND_GRADIENT_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define UGM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define UGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define UGM_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ugm_pkg.sv @@
// Shared types, widths and constants of the upwind gradient magnitude block.
// No dependencies.
package ugm_pkg;

  localparam int UGM_SAMPLE_W  = 24;
  localparam int UGM_INV_W     = 24;
  localparam int UGM_DIFF_W    = UGM_SAMPLE_W + 1;
  localparam int UGM_PROD_W    = 2 * UGM_DIFF_W;
  localparam int UGM_FRAC_INV  = 16;
  localparam int UGM_ROOT_W    = 24;
  localparam int UGM_SUM_W     = 2 * UGM_ROOT_W;
  localparam int UGM_CFG_W     = 24;
  localparam int UGM_CFG_IDX_W = 3;
  localparam int UGM_ARITH_STAGES = 6;
  localparam int UGM_DEPTH     = UGM_ARITH_STAGES + UGM_ROOT_W;

  localparam logic [UGM_INV_W-1:0] UGM_INV_ONE   = 24'd65536;
  localparam logic [UGM_INV_W-1:0] UGM_INV_RESET = 24'd65536;
  localparam logic UGM_MODE_RESET = 1'b1;
  localparam logic UGM_SIGN_RESET = 1'b0;

  typedef logic signed [UGM_SAMPLE_W-1:0] sample_t;
  typedef logic [UGM_INV_W-1:0] inv_t;

  typedef enum logic [UGM_CFG_IDX_W-1:0] {
    REG_SOURCE_MODE   = 3'd0,
    REG_SPEED_SIGN    = 3'd1,
    REG_INV_SPACING_X = 3'd2,
    REG_INV_SPACING_Y = 3'd3,
    REG_INV_SPACING_Z = 3'd4
  } cfg_reg_t;

  // Rounded and clipped difference.
  typedef struct packed {
    sample_t val;
    logic    clip;
  } round_t;

  // Request into the square root pipeline.
  typedef struct packed {
    logic [UGM_SUM_W-1:0] sum;
    logic                 sat;
  } sq_req_t;

endpackage

@@ src/ugm_if.sv @@
// Valid/ready channel interfaces for the input items and the results.
// Depends on ugm_pkg.
interface ugm_in_if;
  import ugm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t speed_value;
  sample_t center_value;
  sample_t x_forward;
  sample_t x_backward;
  sample_t y_forward;
  sample_t y_backward;
  sample_t z_forward;
  sample_t z_backward;

  modport source(output valid, speed_value, center_value, x_forward, x_backward,
                 y_forward, y_backward, z_forward, z_backward, input ready);
  modport sink(input valid, speed_value, center_value, x_forward, x_backward,
               y_forward, y_backward, z_forward, z_backward, output ready);
endinterface

interface ugm_out_if;
  import ugm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [UGM_ROOT_W-1:0] gradient_norm;
  logic                  saturated;

  modport source(output valid, gradient_norm, saturated, input ready);
  modport sink(input valid, gradient_norm, saturated, output ready);
endinterface

@@ src/ugm_isqrt.sv @@
// Pipelined integer square root, rounded down, one result bit per stage.
// Depends on ugm_pkg.
module ugm_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ugm_pkg::sq_req_t                in_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ugm_pkg::UGM_ROOT_W-1:0]  out_root,
  output logic                            out_sat
);
  import ugm_pkg::*;

  localparam int TrialW = UGM_SUM_W + 1;

  logic                  vld    [UGM_ROOT_W];
  logic [UGM_SUM_W-1:0]  rem_q  [UGM_ROOT_W];
  logic [UGM_ROOT_W-1:0] root_q [UGM_ROOT_W];
  logic                  sat_q  [UGM_ROOT_W];
  logic                  rdy    [UGM_ROOT_W+1];

  assign rdy[UGM_ROOT_W] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar k = 0; k < UGM_ROOT_W; k++) begin : g_stage
    localparam int B = UGM_ROOT_W - 1 - k;

    logic                  src_v;
    logic [UGM_SUM_W-1:0]  src_rem;
    logic [UGM_ROOT_W-1:0] src_root;
    logic                  src_sat;
    logic [TrialW-1:0]     trial;
    logic                  fits;

    // Stage input comes from the channel for the first stage.
    if (k == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_rem  = in_req.sum;
      assign src_root = '0;
      assign src_sat  = in_req.sat;
    end else begin : g_rest
      assign src_v    = vld[k-1];
      assign src_rem  = rem_q[k-1];
      assign src_root = root_q[k-1];
      assign src_sat  = sat_q[k-1];
    end

    // Try setting this root bit: (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B).
    assign trial = ({{(TrialW-UGM_ROOT_W){1'b0}}, src_root} << (B + 1))
                 + ({{(TrialW-1){1'b0}}, 1'b1} << (2 * B));
    assign fits  = {1'b0, src_rem} >= trial;

    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        sat_q[k] <= src_sat;
        if (fits) begin
          rem_q[k]  <= src_rem - trial[UGM_SUM_W-1:0];
          root_q[k] <= src_root | (UGM_ROOT_W'(1) << B);
        end else begin
          rem_q[k]  <= src_rem;
          root_q[k] <= src_root;
        end
      end
    end
  end

  assign out_valid = vld[UGM_ROOT_W-1];
  assign out_root  = root_q[UGM_ROOT_W-1];
  assign out_sat   = sat_q[UGM_ROOT_W-1];

endmodule

@@ src/upwind_gradient_magnitude.sv @@
// Upwind gradient magnitude of a 3D level set, one grid point per transfer.
// From input transfer to result an item passes six arithmetic stages
// (difference, scale, round, upwind select, square, sum) and a 24-stage root.
// Throughput is one item per cycle; each stage stalls only when full and blocked.
// Synchronous reset empties the pipeline and loads the register reset values.
module upwind_gradient_magnitude (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ugm_pkg::UGM_CFG_IDX_W-1:0] cfg_index,
  input  logic [ugm_pkg::UGM_CFG_W-1:0]     cfg_data,
  ugm_in_if.sink                            in_ch,
  ugm_out_if.source                         out_ch
);
  import ugm_pkg::*;

  // Configuration registers.
  logic source_mode;
  logic speed_sign;
  inv_t inv_spacing [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mode    <= UGM_MODE_RESET;
      speed_sign     <= UGM_SIGN_RESET;
      inv_spacing[0] <= UGM_INV_RESET;
      inv_spacing[1] <= UGM_INV_RESET;
      inv_spacing[2] <= UGM_INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_MODE:   source_mode    <= cfg_data[0];
        REG_SPEED_SIGN:    speed_sign     <= cfg_data[0];
        REG_INV_SPACING_X: inv_spacing[0] <= cfg_data[UGM_INV_W-1:0];
        REG_INV_SPACING_Y: inv_spacing[1] <= cfg_data[UGM_INV_W-1:0];
        REG_INV_SPACING_Z: inv_spacing[2] <= cfg_data[UGM_INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Round half up to Q12.12 and clip to the sample range.
  function automatic round_t round_sat(input logic signed [UGM_PROD_W-1:0] p);
    logic signed [UGM_PROD_W-1:0] q;
    logic signed [UGM_PROD_W-UGM_FRAC_INV-1:0] r;
    round_t o;
    q = p + UGM_PROD_W'(1 << (UGM_FRAC_INV - 1));
    r = $signed(q[UGM_PROD_W-1:UGM_FRAC_INV]);
    o.clip = 1'b1;
    if (r > $signed((UGM_PROD_W-UGM_FRAC_INV)'(8388607))) begin
      o.val = 24'sh7FFFFF;
    end else if (r < -$signed((UGM_PROD_W-UGM_FRAC_INV)'(8388608))) begin
      o.val = 24'sh800000;
    end else begin
      o.val  = r[UGM_SAMPLE_W-1:0];
      o.clip = 1'b0;
    end
    return o;
  endfunction

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic v1, v2, v3, v4, v5, v6;
  logic r1, r2, r3, r4, r5, r6;
  logic sq_in_ready;

  assign r6 = !v6 || sq_in_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ch.ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r1) v1 <= in_ch.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  // Stage 1: one-sided differences, upwind direction and scale selection.
  // Derivative mode scales by one, which makes rounding an identity.
  logic signed [UGM_DIFF_W-1:0] d1_fwd [3];
  logic signed [UGM_DIFF_W-1:0] d1_bwd [3];
  sample_t                      f_in   [3];
  sample_t                      b_in   [3];
  logic                         pos1;
  logic                         speed_pos;
  logic                         speed_neg;

  logic signed [UGM_DIFF_W-1:0] s1_dp  [3];
  logic signed [UGM_DIFF_W-1:0] s1_dm  [3];
  inv_t                         s1_inv [3];
  logic                         s1_pos;

  assign f_in[0] = in_ch.x_forward;
  assign f_in[1] = in_ch.y_forward;
  assign f_in[2] = in_ch.z_forward;
  assign b_in[0] = in_ch.x_backward;
  assign b_in[1] = in_ch.y_backward;
  assign b_in[2] = in_ch.z_backward;

  assign speed_neg = in_ch.speed_value[UGM_SAMPLE_W-1];
  assign speed_pos = !speed_neg && (|in_ch.speed_value);
  assign pos1      = (source_mode && speed_sign) ? speed_neg : speed_pos;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (source_mode) begin
        d1_fwd[a] = UGM_DIFF_W'(f_in[a]) - UGM_DIFF_W'(in_ch.center_value);
        d1_bwd[a] = UGM_DIFF_W'(in_ch.center_value) - UGM_DIFF_W'(b_in[a]);
      end else begin
        d1_fwd[a] = UGM_DIFF_W'(f_in[a]);
        d1_bwd[a] = UGM_DIFF_W'(b_in[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_ch.valid) begin
      s1_pos <= pos1;
      for (int a = 0; a < 3; a++) begin
        s1_dp[a]  <= d1_fwd[a];
        s1_dm[a]  <= d1_bwd[a];
        s1_inv[a] <= source_mode ? inv_spacing[a] : UGM_INV_ONE;
      end
    end
  end

  // Stage 2: exact Q22.28 products.
  logic signed [UGM_PROD_W-1:0] s2_pp [3];
  logic signed [UGM_PROD_W-1:0] s2_pm [3];
  logic                         s2_pos;

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      s2_pos <= s1_pos;
      for (int a = 0; a < 3; a++) begin
        s2_pp[a] <= s1_dp[a] * $signed({1'b0, s1_inv[a]});
        s2_pm[a] <= s1_dm[a] * $signed({1'b0, s1_inv[a]});
      end
    end
  end

  // Stage 3: rounding and saturation, clips gathered into one flag.
  round_t  rp3 [3];
  round_t  rm3 [3];
  logic    sat3;
  sample_t s3_dp [3];
  sample_t s3_dm [3];
  logic    s3_pos;
  logic    s3_sat;

  always_comb begin
    sat3 = 1'b0;
    for (int a = 0; a < 3; a++) begin
      rp3[a] = round_sat(s2_pp[a]);
      rm3[a] = round_sat(s2_pm[a]);
      sat3   = sat3 | rp3[a].clip | rm3[a].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      s3_pos <= s2_pos;
      s3_sat <= sat3;
      for (int a = 0; a < 3; a++) begin
        s3_dp[a] <= rp3[a].val;
        s3_dm[a] <= rm3[a].val;
      end
    end
  end

  // Stage 4: upwind term per axis, the larger of the two candidates or zero.
  logic signed [UGM_DIFF_W-1:0] cand_a [3];
  logic signed [UGM_DIFF_W-1:0] cand_b [3];
  logic signed [UGM_DIFF_W-1:0] cand_m [3];
  logic [UGM_ROOT_W-1:0]        term4  [3];
  logic [UGM_ROOT_W-1:0]        s4_term [3];
  logic                         s4_sat;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cand_a[a] = s3_pos ? UGM_DIFF_W'(s3_dp[a]) : -UGM_DIFF_W'(s3_dp[a]);
      cand_b[a] = s3_pos ? -UGM_DIFF_W'(s3_dm[a]) : UGM_DIFF_W'(s3_dm[a]);
      cand_m[a] = (cand_a[a] > cand_b[a]) ? cand_a[a] : cand_b[a];
      if (!cand_m[a][UGM_DIFF_W-1] && (|cand_m[a])) begin
        term4[a] = cand_m[a][UGM_ROOT_W-1:0];
      end else begin
        term4[a] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      s4_sat <= s3_sat;
      for (int a = 0; a < 3; a++) begin
        s4_term[a] <= term4[a];
      end
    end
  end

  // Stage 5: squares.
  logic [UGM_SUM_W-1:0] s5_sq [3];
  logic                 s5_sat;

  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      s5_sat <= s4_sat;
      for (int a = 0; a < 3; a++) begin
        s5_sq[a] <= s4_term[a] * s4_term[a];
      end
    end
  end

  // Stage 6: sum of squares, which stays below 2^48.
  sq_req_t s6_req;

  always_ff @(posedge clk) begin
    if (r6 && v5) begin
      s6_req.sum <= s5_sq[0] + s5_sq[1] + s5_sq[2];
      s6_req.sat <= s5_sat;
    end
  end

  // Square root pipeline; its last stage is the output register.
  ugm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_ready  (sq_in_ready),
    .in_req    (s6_req),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_root  (out_ch.gradient_norm),
    .out_sat   (out_ch.saturated)
  );

endmodule

@@ src/ugm_checker.sv @@
// Port-level checker for the upwind gradient magnitude block, with its bind.
// Depends on ugm_pkg and upwind_gradient_magnitude_defines.svh.
`include "upwind_gradient_magnitude_defines.svh"

module ugm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ugm_pkg::UGM_ROOT_W-1:0] gradient_norm,
  input logic                           saturated
);
  import ugm_pkg::*;

  localparam int OccW = $clog2(UGM_DEPTH + 1);

  logic            in_xfer;
  logic            out_xfer;
  logic [OccW-1:0] occ;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Items accepted and not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OccW'(in_xfer) - OccW'(out_xfer);
    end
  end

  // A stalled result holds its value.
  `UGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(gradient_norm) && $stable(saturated), "stalled result changed")

  // With the sink ready the whole pipeline moves, so the input must be ready.
  `UGM_ASSERT_IMPL(a_flow, out_ready, in_ready, "input stalled while output ready")

  // No result without an item in flight.
  `UGM_ASSERT_IMPL(a_no_invent, occ == '0, !out_valid, "result with no item in flight")

  // Reset empties the pipeline.
  `UGM_ASSERT_RST(a_reset_empty, rst, !out_valid, "result valid after reset")

endmodule

bind upwind_gradient_magnitude ugm_checker u_ugm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .gradient_norm (out_ch.gradient_norm),
  .saturated     (out_ch.saturated)
);

@@ test/testbench.sv @@
// Self-checking testbench for the upwind gradient magnitude pipeline.
// Depends on ugm_pkg, the ugm_in_if/ugm_out_if channels and the block itself.
// Directed points, back-pressure and random phases are checked against a behavioural predictor.
module testbench;
  import ugm_pkg::*;

  localparam sample_t SAMPLE_MAX_V = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN_V = 24'sh800000;
  localparam logic MODE_DERIVATIVE = 1'b0;
  localparam logic MODE_STENCIL    = 1'b1;
  localparam logic SIGN_PLUS       = 1'b0;
  localparam logic SIGN_MINUS      = 1'b1;
  localparam inv_t INV_MAX         = 24'hFFFFFF;
  localparam inv_t INV_HALF        = 24'h008000;
  localparam inv_t INV_TINY        = 24'h000001;
  localparam int SETTLE_CYCLES     = UGM_DEPTH + 10;
  localparam int RX_HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int RANDOM_ITEMS      = 1660;
  localparam int REPORT_LIMIT      = 10;

  typedef struct packed {
    sample_t speed;
    sample_t center;
    sample_t xf;
    sample_t xb;
    sample_t yf;
    sample_t yb;
    sample_t zf;
    sample_t zb;
  } grid_point_t;

  typedef struct packed {
    logic [UGM_ROOT_W-1:0] norm;
    logic                  sat;
  } norm_result_t;

  typedef struct packed {
    logic mode;
    logic sign;
    inv_t inv_x;
    inv_t inv_y;
    inv_t inv_z;
  } grid_settings_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [UGM_CFG_IDX_W-1:0] cfg_index;
  logic [UGM_CFG_W-1:0]     cfg_data;

  ugm_in_if  in_ch ();
  ugm_out_if out_ch ();

  upwind_gradient_magnitude uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Register copy held by the predictor, starting from the reset values.
  logic cfg_mode  = UGM_MODE_RESET;
  logic cfg_sign  = UGM_SIGN_RESET;
  inv_t cfg_inv_x = UGM_INV_RESET;
  inv_t cfg_inv_y = UGM_INV_RESET;
  inv_t cfg_inv_z = UGM_INV_RESET;

  norm_result_t expected_norms[$];
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_gaps_on = 1'b1;
  bit  rx_hold_req = 1'b0;
  bit  rx_holding = 1'b0;

  // Clock generation.
  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // Scales one difference by a Q8.16 reciprocal, rounds half up and clips to Q12.12.
  function automatic longint scaled_diff(longint diff, inv_t inv, output logic clipped);
    longint prod;
    prod = diff * longint'(inv) + 64'sd32768;
    prod = prod >>> UGM_FRAC_INV;
    clipped = 1'b0;
    if (prod > longint'(SAMPLE_MAX_V)) begin
      prod = longint'(SAMPLE_MAX_V);
      clipped = 1'b1;
    end
    if (prod < longint'(SAMPLE_MIN_V)) begin
      prod = longint'(SAMPLE_MIN_V);
      clipped = 1'b1;
    end
    return prod;
  endfunction

  // Integer square root rounded down, built one result bit at a time.
  function automatic logic [UGM_ROOT_W-1:0] floor_sqrt(longint unsigned v);
    logic [UGM_ROOT_W-1:0] root;
    logic [UGM_ROOT_W-1:0] trial;
    longint unsigned sq;
    root = '0;
    for (int i = UGM_ROOT_W - 1; i >= 0; i--) begin
      trial = root | (UGM_ROOT_W'(1) << i);
      sq = longint'(trial) * longint'(trial);
      if (sq <= v) root = trial;
    end
    return root;
  endfunction

  // Expected result of one grid point under the current register copy.
  function automatic norm_result_t upwind_norm(grid_point_t p);
    longint centre, dplus, dminus, term_a, term_b, term_max;
    longint fwd [3];
    longint bwd [3];
    inv_t inv [3];
    longint unsigned sum_sq;
    logic pos, clip_p, clip_m, any_clip;
    norm_result_t r;
    fwd[0] = p.xf; bwd[0] = p.xb;
    fwd[1] = p.yf; bwd[1] = p.yb;
    fwd[2] = p.zf; bwd[2] = p.zb;
    inv[0] = cfg_inv_x; inv[1] = cfg_inv_y; inv[2] = cfg_inv_z;
    centre = p.center;
    any_clip = 1'b0;
    sum_sq = 0;
    // Derivative mode ignores the speed sign register; zero speed is never positive.
    if (cfg_mode == MODE_STENCIL) begin
      pos = (cfg_sign == SIGN_MINUS) ? (p.speed < 0) : (p.speed > 0);
    end else begin
      pos = p.speed > 0;
    end
    for (int a = 0; a < 3; a++) begin
      if (cfg_mode == MODE_STENCIL) begin
        dplus  = scaled_diff(fwd[a] - centre, inv[a], clip_p);
        dminus = scaled_diff(centre - bwd[a], inv[a], clip_m);
        any_clip = any_clip | clip_p | clip_m;
      end else begin
        dplus  = fwd[a];
        dminus = bwd[a];
      end
      term_a = pos ? dplus : -dplus;
      term_b = pos ? -dminus : dminus;
      term_max = (term_a > term_b) ? term_a : term_b;
      if (term_max < 0) term_max = 0;
      sum_sq += longint'(term_max * term_max);
    end
    r.norm = floor_sqrt(sum_sq);
    r.sat  = any_clip;
    return r;
  endfunction

  // ---------------------------------------------------------------- monitors

  // Every input transfer queues its expected result.
  always @(posedge clk) begin : input_monitor
    grid_point_t pt;
    if (!rst && in_ch.valid && in_ch.ready) begin
      pt.speed  = in_ch.speed_value;
      pt.center = in_ch.center_value;
      pt.xf = in_ch.x_forward;
      pt.xb = in_ch.x_backward;
      pt.yf = in_ch.y_forward;
      pt.yb = in_ch.y_backward;
      pt.zf = in_ch.z_forward;
      pt.zb = in_ch.z_backward;
      expected_norms.push_back(upwind_norm(pt));
    end
  end

  // Every output transfer is compared with the oldest expectation.
  always @(posedge clk) begin : result_checker
    norm_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_norms.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: norm %0d saturated %0b",
                   out_ch.gradient_norm, out_ch.saturated);
      end else begin
        want = expected_norms.pop_front();
        if (out_ch.gradient_norm !== want.norm || out_ch.saturated !== want.sat) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: norm expected %0d actual %0d, saturated expected %0b actual %0b",
                     want.norm, out_ch.gradient_norm, want.sat, out_ch.saturated);
        end
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("upwind_gradient_magnitude regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- random helpers

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5, 6:    return sample_t'(int'($urandom_range(0, 16383)) - 8192);
      7:          return SAMPLE_MAX_V;
      8:          return SAMPLE_MIN_V;
      default:    return sample_t'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  // A neighbour is either close to the centre sample or anything at all.
  function automatic sample_t rand_neighbour(sample_t c);
    if ($urandom_range(0, 1) == 0) return rand_sample();
    return sample_t'(c + sample_t'(int'($urandom_range(0, 8191)) - 4096));
  endfunction

  function automatic grid_point_t rand_point();
    grid_point_t p;
    p.speed  = ($urandom_range(0, 7) == 0) ? sample_t'(0) : rand_sample();
    p.center = rand_sample();
    p.xf = rand_neighbour(p.center);
    p.xb = rand_neighbour(p.center);
    p.yf = rand_neighbour(p.center);
    p.yb = rand_neighbour(p.center);
    p.zf = rand_neighbour(p.center);
    p.zb = rand_neighbour(p.center);
    return p;
  endfunction

  function automatic inv_t rand_inv();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return INV_MAX;
      2:       return UGM_INV_ONE;
      3:       return inv_t'($urandom_range(0, 131071));
      default: return inv_t'($urandom);
    endcase
  endfunction

  function automatic grid_settings_t rand_settings();
    grid_settings_t s;
    s.mode  = 1'($urandom_range(0, 1));
    s.sign  = 1'($urandom_range(0, 1));
    s.inv_x = rand_inv();
    s.inv_y = rand_inv();
    s.inv_z = rand_inv();
    return s;
  endfunction

  function automatic grid_point_t point_of(sample_t speed, sample_t center,
                                           sample_t xf, sample_t xb, sample_t yf,
                                           sample_t yb, sample_t zf, sample_t zb);
    grid_point_t p;
    p.speed = speed; p.center = center;
    p.xf = xf; p.xb = xb; p.yf = yf; p.yb = yb; p.zf = zf; p.zb = zb;
    return p;
  endfunction

  function automatic grid_settings_t settings_of(logic mode, logic sign,
                                                 inv_t ix, inv_t iy, inv_t iz);
    grid_settings_t s;
    s.mode = mode; s.sign = sign; s.inv_x = ix; s.inv_y = iy; s.inv_z = iz;
    return s;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Result receiver: random stalls, or one long hold-off when asked for.
  initial begin : result_receiver
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_holding  = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else begin
        stall = rx_gaps_on ? pick_gap() : 0;
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offers one grid point, after an optional gap, and returns once it has been transferred.
  task automatic send_point(input grid_point_t p);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.speed_value  <= p.speed;
    in_ch.center_value <= p.center;
    in_ch.x_forward    <= p.xf;
    in_ch.x_backward   <= p.xb;
    in_ch.y_forward    <= p.yf;
    in_ch.y_backward   <= p.yb;
    in_ch.z_forward    <= p.zf;
    in_ch.z_backward   <= p.zb;
    in_ch.valid        <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering, waits until every expected result has arrived, then lets the pipeline settle.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_norms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers once the block is idle, then an unused index that must be ignored.
  task automatic apply_settings(input grid_settings_t s);
    logic [UGM_CFG_W-1:0] data;
    wait_results_drained();
    for (int i = REG_SOURCE_MODE; i <= REG_INV_SPACING_Z; i++) begin
      data = UGM_CFG_W'($urandom);
      case (cfg_reg_t'(i))
        REG_SOURCE_MODE: begin
          data[0] = s.mode;
          cfg_mode = s.mode;
        end
        REG_SPEED_SIGN: begin
          data[0] = s.sign;
          cfg_sign = s.sign;
        end
        REG_INV_SPACING_X: begin
          data = s.inv_x;
          cfg_inv_x = s.inv_x;
        end
        REG_INV_SPACING_Y: begin
          data = s.inv_y;
          cfg_inv_y = s.inv_y;
        end
        REG_INV_SPACING_Z: begin
          data = s.inv_z;
          cfg_inv_z = s.inv_z;
        end
        default: ;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= UGM_CFG_IDX_W'(i);
      cfg_data  <= data;
      @(posedge clk);
    end
    cfg_index <= REG_INV_SPACING_Z + UGM_CFG_IDX_W'($urandom_range(1, 3));
    cfg_data  <= UGM_CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // Register reset values: stencil mode, plus sign, unit reciprocal spacings.
  task automatic test_reset_values();
    send_point(point_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_point(point_of(1, 0, 4096, -4096, 0, 0, 2048, 8192));
    send_point(point_of(-1, 100, 50, 300, -7, 900, 100, 100));
  endtask

  // Derivative mode at the field extremes, including negation of the most negative value.
  task automatic test_derivative_extremes();
    apply_settings(settings_of(MODE_DERIVATIVE, SIGN_MINUS, rand_inv(), rand_inv(), rand_inv()));
    send_point(point_of(1, SAMPLE_MAX_V, SAMPLE_MIN_V, SAMPLE_MIN_V, SAMPLE_MIN_V,
                        SAMPLE_MIN_V, SAMPLE_MIN_V, SAMPLE_MIN_V));
    send_point(point_of(0, 0, SAMPLE_MIN_V, SAMPLE_MIN_V, SAMPLE_MIN_V,
                        SAMPLE_MIN_V, SAMPLE_MIN_V, SAMPLE_MIN_V));
    send_point(point_of(SAMPLE_MIN_V, SAMPLE_MIN_V, SAMPLE_MAX_V, SAMPLE_MAX_V,
                        SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MAX_V));
    send_point(point_of(SAMPLE_MAX_V, 0, SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MAX_V,
                        SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MAX_V));
    send_point(point_of(1, 0, 0, 0, -1, 1, 0, 0));
    send_point(point_of(-1, 0, SAMPLE_MAX_V, SAMPLE_MIN_V, SAMPLE_MIN_V,
                        SAMPLE_MAX_V, -1, 1));
    apply_settings(settings_of(MODE_DERIVATIVE, SIGN_PLUS, UGM_INV_ONE, UGM_INV_ONE,
                               UGM_INV_ONE));
    send_point(point_of(SAMPLE_MIN_V, 0, SAMPLE_MIN_V, SAMPLE_MAX_V, SAMPLE_MIN_V,
                        SAMPLE_MAX_V, SAMPLE_MIN_V, SAMPLE_MAX_V));
    send_point(point_of(5, 0, 4096, -4096, -4096, 4096, 12, -12));
  endtask

  // Stencil mode: clipping at the largest reciprocal, zero and tiny reciprocals,
  // and half-up rounding of negative differences.
  task automatic test_stencil_scaling();
    apply_settings(settings_of(MODE_STENCIL, SIGN_MINUS, INV_MAX, INV_MAX, INV_MAX));
    send_point(point_of(SAMPLE_MIN_V, SAMPLE_MIN_V, SAMPLE_MAX_V, SAMPLE_MAX_V,
                        SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MAX_V));
    send_point(point_of(SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MIN_V, SAMPLE_MIN_V,
                        SAMPLE_MIN_V, SAMPLE_MIN_V, SAMPLE_MIN_V, SAMPLE_MIN_V));
    send_point(point_of(0, 0, 1, -1, -1, 1, 1, 1));
    apply_settings(settings_of(MODE_STENCIL, SIGN_PLUS, '0, INV_TINY, INV_HALF));
    send_point(point_of(1, 0, 1, -1, -1, 1, -3, 3));
    send_point(point_of(-1, 0, 1, -1, -1, 1, -3, 3));
    send_point(point_of(SAMPLE_MAX_V, SAMPLE_MIN_V, SAMPLE_MAX_V, SAMPLE_MAX_V,
                        SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MAX_V, SAMPLE_MAX_V));
  endtask

  // The receiver holds off for a long stretch while points keep coming, so the
  // pipeline fills and must stall its input.
  task automatic test_input_backpressure();
    apply_settings(rand_settings());
    tx_gaps_on  = 1'b0;
    rx_hold_req = 1'b1;
    wait (rx_holding);
    for (int n = 0; n < 120; n++) send_point(rand_point());
    tx_gaps_on = 1'b1;
  endtask

  // Random phases, each under fresh register settings and idling on or off per side.
  task automatic test_random_phases();
    int sent;
    int phase_len;
    int pause_at;
    int phase;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      apply_settings(rand_settings());
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(40, 160);
      // The first phase always pauses until every result is back; later ones sometimes do.
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ?
                 $urandom_range(1, phase_len - 1) : -1;
      for (int n = 0; n < phase_len; n++) begin
        if (n == pause_at) wait_results_drained();
        send_point(rand_point());
      end
      sent += phase_len;
      phase++;
    end
    rx_gaps_on = 1'b1;
    tx_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : main_sequence
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_ch.valid        = 1'b0;
    in_ch.speed_value  = '0;
    in_ch.center_value = '0;
    in_ch.x_forward    = '0;
    in_ch.x_backward   = '0;
    in_ch.y_forward    = '0;
    in_ch.y_backward   = '0;
    in_ch.z_forward    = '0;
    in_ch.z_backward   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_derivative_extremes();
    test_stencil_scaling();
    test_input_backpressure();
    test_random_phases();
    wait_results_drained();

    // Anything still expected at this point counts against the run.
    mismatch_count += expected_norms.size();
    if (mismatch_count == 0) begin
      $display("upwind_gradient_magnitude regression: pass");
    end else begin
      $display("upwind_gradient_magnitude regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ugm_pkg.sv
src/ugm_if.sv
src/ugm_isqrt.sv
src/upwind_gradient_magnitude.sv
src/ugm_checker.sv
test/testbench.sv
